@@ rtl/core/bmmd_pkg.sv @@
// Package for the banked memory map decoder: target codes, address
// constants and the latch write request type. No dependencies.
`default_nettype none

package bmmd_pkg;

  typedef enum logic [2:0] {
    TGT_RAM     = 3'd0,
    TGT_CARD    = 3'd1,
    TGT_ROM     = 3'd2,
    TGT_LATCH   = 3'd3,
    TGT_OPEN    = 3'd4,
    TGT_UART    = 3'd5,
    TGT_ANSWER  = 3'd6,
    TGT_HANDOFF = 3'd7
  } tgt_t;

  localparam logic CFG_ROM_BASE = 1'b0;
  localparam logic CFG_HANDOFF  = 1'b1;

  localparam logic [15:0] ROM_BASE_RST = 16'hC000;
  localparam logic [15:0] HANDOFF_RST  = 16'hFFFF;
  localparam logic [15:0] RAM_OFFSET   = 16'h8000;
  localparam logic [7:0]  UART_PAGE_LO = 8'h00;
  localparam logic [7:0]  UART_PAGE_HI = 8'hA0;
  localparam logic [7:0]  UART_FIRST   = 8'h20;
  localparam logic [7:0]  UART_LAST    = 8'h27;
  localparam logic [7:0]  ANSWER_OFF   = 8'h33;
  localparam logic [11:0] LATCH_PAGE   = 12'hF00;
  localparam logic [7:0]  OPEN_BUS     = 8'hFF;

  localparam int unsigned LATCH_DEPTH = 16;
  localparam int unsigned LATCH_AW    = 4;

  typedef struct packed {
    logic                we;
    logic [LATCH_AW-1:0] idx;
    logic [7:0]          data;
  } latch_wr_t;

  typedef struct packed {
    logic        mode;
    logic        space;
    logic [15:0] addr;
    logic [7:0]  write_data;
    logic        card_claims;
    logic [7:0]  card_data;
  } req_t;

  typedef struct packed {
    tgt_t        target;
    logic [15:0] target_addr;
    logic [7:0]  read_data;
    logic [1:0]  uart_index;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/core/bmmd_latch_file.sv @@
// Sixteen 8-bit local I/O latches, cleared at reset, one write and one read port.
// Depends on bmmd_pkg.
`default_nettype none

module bmmd_latch_file
  import bmmd_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire latch_wr_t           wr,
  input  wire logic [LATCH_AW-1:0] rd_idx,
  output logic [7:0]               rd_data
);

  logic [7:0] latch_r [LATCH_DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LATCH_DEPTH; i++) latch_r[i] <= '0;
    end else if (wr.we) begin
      latch_r[wr.idx] <= wr.data;
    end
  end

  assign rd_data = latch_r[rd_idx];

endmodule

`default_nettype wire

@@ rtl/core/bmmd_decode.sv @@
// Combinational decode of one bus request into target, address and read byte.
// Depends on bmmd_pkg; read byte of the latch file comes in from bmmd_latch_file.
`default_nettype none

module bmmd_decode
  import bmmd_pkg::*;
(
  input  wire req_t        req,
  input  wire logic [15:0] rom_base,
  input  wire logic [15:0] handoff_address,
  input  wire logic [7:0]  latch_data,
  output res_t             res,
  output latch_wr_t        latch_wr
);

  logic [7:0] hi;
  logic [7:0] off;
  logic       uart_page;
  logic       uart_hit;
  logic       answer_hit;
  logic       latch_hit;
  logic       upper;
  logic       below_rom;
  logic       wr;

  always_comb begin
    hi         = req.addr[15:8];
    off        = req.addr[7:0];
    wr         = req.mode;
    uart_page  = (hi == UART_PAGE_LO) || (hi == UART_PAGE_HI);
    uart_hit   = uart_page && (off >= UART_FIRST) && (off <= UART_LAST);
    answer_hit = uart_page && (off == ANSWER_OFF);
    latch_hit  = (req.addr[15:4] == LATCH_PAGE);
    upper      = req.addr[15];
    below_rom  = req.addr < rom_base;

    res.target      = TGT_OPEN;
    res.target_addr = req.addr;
    res.read_data   = '0;
    res.uart_index  = '0;

    latch_wr.we   = 1'b0;
    latch_wr.idx  = req.addr[LATCH_AW-1:0];
    latch_wr.data = req.write_data;

    if (req.space && wr && (req.addr == handoff_address)) begin
      res.target = TGT_HANDOFF;
    end else if (req.space && uart_hit) begin
      res.target     = TGT_UART;
      res.uart_index = off[1:0];
    end else if (req.space && answer_hit) begin
      res.target = wr ? TGT_OPEN : TGT_ANSWER;
    end else if (req.space && latch_hit) begin
      res.target  = TGT_LATCH;
      latch_wr.we = wr;
      if (!wr) res.read_data = latch_data;
    end else if (req.space && upper && req.card_claims) begin
      res.target = TGT_CARD;
      if (!wr) res.read_data = req.card_data;
    end else if (req.space && upper && below_rom) begin
      res.target = TGT_OPEN;
      if (!wr) res.read_data = OPEN_BUS;
    end else if (!upper) begin
      res.target      = TGT_RAM;
      res.target_addr = req.addr + RAM_OFFSET;
    end else if (wr) begin
      res.target = TGT_OPEN;
    end else if (below_rom) begin
      if (req.card_claims) begin
        res.target    = TGT_CARD;
        res.read_data = req.card_data;
      end else begin
        res.target    = TGT_OPEN;
        res.read_data = OPEN_BUS;
      end
    end else begin
      res.target = TGT_ROM;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/banked_memory_map_decoder_top.sv @@
// Top level of the banked memory map decoder: input register, decode, result
// register and config registers. Depends on bmmd_pkg, bmmd_decode, bmmd_latch_file.
//
//  channel | direction | tdata / data                       | tuser / index
//  in_     | slave     | addr, write_data, card_claims, card_data | mode, space
//  out_    | master    | target_addr, read_data, uart_index | target
//  cfg_    | write     | 16-bit register value              | 1-bit register index
//
// Each request passes through the input register and then the result register;
// one request per cycle is sustained while out_tready stays high.
// Latch writes take effect as the request leaves the input register, so the
// next request already sees them. Synchronous active-low reset clears the
// latches and loads rom_base 0xC000 and handoff_address 0xFFFF.
// A stalled result holds; the input register drains into it once it frees.
`default_nettype none

module banked_memory_map_decoder_top
  import bmmd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // addr[15:0], write_data[23:16], card_claims[24], card_data[32:25]
  input  wire logic [1:0]  in_tuser,   // mode[0], space[1]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // target_addr[15:0], read_data[23:16], uart_index[25:24]
  output logic [2:0]       out_tuser,  // target[2:0]
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data
);

  logic        s1_valid_r;
  req_t        s1_req_r;
  logic        out_valid_r;
  res_t        out_res_r;
  logic [15:0] rom_base_r;
  logic [15:0] handoff_r;

  logic       adv;
  req_t       in_req;
  res_t       res;
  latch_wr_t  latch_wr;
  latch_wr_t  latch_wr_gated;
  logic [7:0] latch_data;

  assign in_req.addr        = in_tdata[15:0];
  assign in_req.write_data  = in_tdata[23:16];
  assign in_req.card_claims = in_tdata[24];
  assign in_req.card_data   = in_tdata[32:25];
  assign in_req.mode        = in_tuser[0];
  assign in_req.space       = in_tuser[1];

  assign adv       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;
  assign cfg_ready = 1'b1;

  bmmd_decode u_decode (
    .req             (s1_req_r),
    .rom_base        (rom_base_r),
    .handoff_address (handoff_r),
    .latch_data      (latch_data),
    .res             (res),
    .latch_wr        (latch_wr)
  );

  always_comb begin
    latch_wr_gated    = latch_wr;
    latch_wr_gated.we = latch_wr.we && adv;
  end

  bmmd_latch_file u_latches (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (latch_wr_gated),
    .rd_idx  (s1_req_r.addr[LATCH_AW-1:0]),
    .rd_data (latch_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      rom_base_r  <= ROM_BASE_RST;
      handoff_r   <= HANDOFF_RST;
    end else begin
      if (in_tready) s1_valid_r <= in_tvalid;
      if (adv) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ROM_BASE: rom_base_r <= cfg_data;
          CFG_HANDOFF:  handoff_r  <= cfg_data;
          default:      ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) s1_req_r <= in_req;
    if (adv) out_res_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_res_r.uart_index, out_res_r.read_data,
                       out_res_r.target_addr};
  assign out_tuser  = out_res_r.target;

  a_ram_upper: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_res_r.target == TGT_RAM) |-> out_res_r.target_addr[15])
    else $error("RAM target address outside upper half");

  a_uart_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_res_r.uart_index != 2'd0) |-> (out_res_r.target == TGT_UART))
    else $error("UART index set for non-UART target");

  a_rd_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_res_r.read_data != 8'd0) |->
      (out_res_r.target == TGT_LATCH) || (out_res_r.target == TGT_CARD) ||
      (out_res_r.target == TGT_OPEN))
    else $error("read data from a target that supplies none");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !adv |=> s1_valid_r && $stable(s1_req_r))
    else $error("input register lost a stalled request");

endmodule

`default_nettype wire
